[rtl/core/ffha_pkg.sv]
// Shared constants and types for the first-fit heap allocator.
`default_nettype none
package ffha_pkg;
  localparam int unsigned HEADER_BYTES = 12;
  localparam int unsigned SPLIT_SLACK  = 16;
  localparam int unsigned ARENA_MAX    = 65536;
  localparam int unsigned ARENA_MIN    = 64;
  localparam int unsigned HDR_WORDS    = ARENA_MAX / 4;
  localparam int unsigned HDR_AW       = $clog2(HDR_WORDS);

  // result status codes
  localparam logic [1:0] ST_ALLOC_OK   = 2'd0;
  localparam logic [1:0] ST_ALLOC_FAIL = 2'd1;
  localparam logic [1:0] ST_FREED      = 2'd2;
  localparam logic [1:0] ST_FREE_BAD   = 2'd3;

  // command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // one header word: block start flag, used mark, payload length
  typedef struct packed {
    logic        start;
    logic        used;
    logic [15:0] len;
  } hdr_t;
endpackage
`default_nettype wire

[rtl/core/first_fit_heap_allocator_top.sv]
// Top level of the first-fit heap allocator with coalescing.
// An allocate walks the blocks from the start of the arena until one fits (a zero-size
//   request goes straight to the result); a free checks the header, marks the block free and
//   walks the arena, merging each free block with the free blocks after it; a bad free skips the walk.
// Throughput: one word at a time; in_tready is high only while the sequencer is idle.
// Reset (rst_n low, synchronous) and every arena_bytes write start a pass that
//   clears the header memory; no word is accepted during it.
`default_nettype none
module first_fit_heap_allocator_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // request_bytes[16:0], address[32:17], zeros
  input  wire logic [0:0]  in_tuser,   // command[0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // payload_offset[15:0], used_bytes[32:16], zeros
  output logic [1:0]       out_tuser,  // status[1:0]
  input  wire logic        cfg_wr_en,
  input  wire logic [16:0] cfg_wr_data
);
  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_A_RD   = 4'd2;
  localparam logic [3:0] S_A_CHK  = 4'd3;
  localparam logic [3:0] S_A_WR   = 4'd4;
  localparam logic [3:0] S_F_CHK  = 4'd5;
  localparam logic [3:0] S_C_RD   = 4'd6;
  localparam logic [3:0] S_C_CHK  = 4'd7;
  localparam logic [3:0] S_C_NXRD = 4'd8;
  localparam logic [3:0] S_C_NX   = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  localparam logic [17:0] HDR18   = 18'(ffha_pkg::HEADER_BYTES);
  localparam logic [17:0] SPLIT18 = 18'(ffha_pkg::HEADER_BYTES + ffha_pkg::SPLIT_SLACK);
  localparam logic [ffha_pkg::HDR_AW-1:0] CLR_STEP = {{(ffha_pkg::HDR_AW-1){1'b0}}, 1'b1};

  logic [3:0]  state_r, state_nxt;
  logic [16:0] arena_r, arena_nxt;
  logic [16:0] used_r, used_nxt;
  logic [17:0] pos_r, pos_nxt;
  logic [17:0] nx_r, nx_nxt;
  logic [15:0] cur_len_r, cur_len_nxt;
  logic [17:0] want_r, want_nxt;
  logic [ffha_pkg::HDR_AW-1:0] clr_r, clr_nxt;
  logic [1:0]  res_st_r, res_st_nxt;
  logic [15:0] res_off_r, res_off_nxt;

  logic        out_valid_r;
  logic [1:0]  out_st_r;
  logic [15:0] out_off_r;
  logic [16:0] out_used_r;

  // header memory
  ffha_pkg::hdr_t hdr_mem [ffha_pkg::HDR_WORDS];
  ffha_pkg::hdr_t rd_r;
  logic [ffha_pkg::HDR_AW-1:0] raddr, waddr;
  logic           re, we;
  ffha_pkg::hdr_t wdata;

  always_ff @(posedge clk) begin
    if (we) hdr_mem[waddr] <= wdata;
    if (re) rd_r <= hdr_mem[raddr];
  end

  // input fields
  logic        cmd;
  logic [16:0] req;
  logic [15:0] addr;
  assign cmd  = in_tuser[0];
  assign req  = in_tdata[16:0];
  assign addr = in_tdata[32:17];

  logic [17:0] rd_next;
  assign rd_next = pos_r + HDR18 + {2'd0, rd_r.len};

  logic [17:0] free_pos;
  assign free_pos = {2'd0, addr} - HDR18;

  logic [16:0] cfg_sat;
  always_comb begin
    if (cfg_wr_data > 17'(ffha_pkg::ARENA_MAX))      cfg_sat = 17'(ffha_pkg::ARENA_MAX);
    else if (cfg_wr_data < 17'(ffha_pkg::ARENA_MIN)) cfg_sat = 17'(ffha_pkg::ARENA_MIN);
    else                                             cfg_sat = cfg_wr_data;
  end

  assign in_tready = (state_r == S_IDLE);

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    arena_nxt   = arena_r;
    used_nxt    = used_r;
    pos_nxt     = pos_r;
    nx_nxt      = nx_r;
    cur_len_nxt = cur_len_r;
    want_nxt    = want_r;
    clr_nxt     = clr_r;
    res_st_nxt  = res_st_r;
    res_off_nxt = res_off_r;
    re    = 1'b0;
    raddr = pos_r[15:2];
    we    = 1'b0;
    waddr = pos_r[15:2];
    wdata = '0;
    case (state_r)
      S_CLR: begin
        we    = 1'b1;
        waddr = clr_r;
        if (clr_r == '0) begin
          wdata.start = 1'b1;
          wdata.len   = 16'(arena_r - 17'(ffha_pkg::HEADER_BYTES));
        end
        clr_nxt = clr_r + CLR_STEP;
        if (clr_r == '1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          pos_nxt = '0;
          if (cmd == ffha_pkg::CMD_ALLOC) begin
            // 18 bits so that the largest request cannot wrap to a small size
            want_nxt    = (18'(req) + 18'd3) & ~18'd3;
            res_st_nxt  = ffha_pkg::ST_ALLOC_FAIL;
            res_off_nxt = '0;
            state_nxt   = (req == '0) ? S_DONE : S_A_RD;
          end else begin
            res_st_nxt  = ffha_pkg::ST_FREE_BAD;
            res_off_nxt = '0;
            pos_nxt     = free_pos;
            if (addr >= 16'(ffha_pkg::HEADER_BYTES) && free_pos < {1'b0, arena_r} &&
                free_pos[1:0] == 2'd0) begin
              re        = 1'b1;
              raddr     = free_pos[15:2];
              state_nxt = S_F_CHK;
            end else begin
              state_nxt = S_DONE;
            end
          end
        end
      end
      S_A_RD: begin
        if (pos_r >= {1'b0, arena_r}) begin
          state_nxt = S_DONE;
        end else begin
          re        = 1'b1;
          state_nxt = S_A_CHK;
        end
      end
      S_A_CHK: begin
        if (!rd_r.used && {2'd0, rd_r.len} >= want_r) begin
          res_st_nxt  = ffha_pkg::ST_ALLOC_OK;
          res_off_nxt = 16'(pos_r + HDR18);
          if ({2'd0, rd_r.len} >= want_r + SPLIT18) begin
            // split: new free block after the trimmed payload
            we          = 1'b1;
            waddr       = 14'((pos_r + HDR18 + want_r) >> 2);
            wdata.start = 1'b1;
            wdata.len   = 16'({2'd0, rd_r.len} - want_r - HDR18);
            cur_len_nxt = 16'(want_r);
          end else begin
            cur_len_nxt = rd_r.len;
          end
          state_nxt = S_A_WR;
        end else begin
          pos_nxt   = rd_next;
          state_nxt = S_A_RD;
        end
      end
      S_A_WR: begin
        we          = 1'b1;
        wdata.start = 1'b1;
        wdata.used  = 1'b1;
        wdata.len   = cur_len_r;
        used_nxt    = used_r + 17'(ffha_pkg::HEADER_BYTES) + {1'b0, cur_len_r};
        state_nxt   = S_DONE;
      end
      S_F_CHK: begin
        if (rd_r.start && rd_r.used) begin
          we          = 1'b1;
          wdata.start = 1'b1;
          wdata.len   = rd_r.len;
          used_nxt    = used_r - 17'(ffha_pkg::HEADER_BYTES) - {1'b0, rd_r.len};
          res_st_nxt  = ffha_pkg::ST_FREED;
          pos_nxt     = '0;
          state_nxt   = S_C_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      // merge walk
      S_C_RD: begin
        if (pos_r >= {1'b0, arena_r}) begin
          state_nxt = S_DONE;
        end else begin
          re        = 1'b1;
          state_nxt = S_C_CHK;
        end
      end
      S_C_CHK: begin
        if (rd_r.used) begin
          pos_nxt   = rd_next;
          state_nxt = S_C_RD;
        end else begin
          cur_len_nxt = rd_r.len;
          nx_nxt      = rd_next;
          state_nxt   = S_C_NXRD;
        end
      end
      S_C_NXRD: begin
        if (nx_r < {1'b0, arena_r}) begin
          re        = 1'b1;
          raddr     = nx_r[15:2];
          state_nxt = S_C_NX;
        end else begin
          we          = 1'b1;
          wdata.start = 1'b1;
          wdata.len   = cur_len_r;
          pos_nxt     = nx_r;
          state_nxt   = S_C_RD;
        end
      end
      S_C_NX: begin
        if (!rd_r.used) begin
          we          = 1'b1;
          waddr       = nx_r[15:2];
          wdata.len   = rd_r.len;
          cur_len_nxt = 16'({2'd0, cur_len_r} + HDR18 + {2'd0, rd_r.len});
          nx_nxt      = nx_r + HDR18 + {2'd0, rd_r.len};
          state_nxt   = S_C_NXRD;
        end else begin
          we          = 1'b1;
          wdata.start = 1'b1;
          wdata.len   = cur_len_r;
          pos_nxt     = nx_r;
          state_nxt   = S_C_RD;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    // arena write restarts the clearing pass
    if (cfg_wr_en) begin
      arena_nxt = cfg_sat;
      used_nxt  = 17'(ffha_pkg::HEADER_BYTES);
      clr_nxt   = '0;
      state_nxt = S_CLR;
    end
  end

  logic load_out;
  assign load_out = (state_r == S_DONE) && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      arena_r     <= 17'(ffha_pkg::ARENA_MAX);
      used_r      <= 17'(ffha_pkg::HEADER_BYTES);
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      arena_r <= arena_nxt;
      used_r  <= used_nxt;
      clr_r   <= clr_nxt;
      if (load_out)                       out_valid_r <= 1'b1;
      else if (out_tready)                out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pos_r     <= pos_nxt;
    nx_r      <= nx_nxt;
    cur_len_r <= cur_len_nxt;
    want_r    <= want_nxt;
    res_st_r  <= res_st_nxt;
    res_off_r <= res_off_nxt;
    if (load_out) begin
      out_st_r   <= res_st_r;
      out_off_r  <= res_off_r;
      out_used_r <= used_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_st_r;
  assign out_tdata  = {7'd0, out_used_r, out_off_r};
endmodule
`default_nettype wire

[rtl/core/ffha_checker.sv]
// Port-level checks for the heap allocator, bound to the top level.
`default_nettype none
module ffha_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata,
  input wire logic [1:0]  out_tuser,
  input wire logic        cfg_wr_en
);
  // clearing pass blocks input right after reset
  a_rst_busy: assert property (@(posedge clk) !rst_n |=> !in_tready)
    else $error("input ready right after reset");

  // one word at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("ready again right after accept");

  // offset is zero unless allocated
  a_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ffha_pkg::ST_ALLOC_OK) |-> out_tdata[15:0] == 16'd0)
    else $error("nonzero offset on non-allocate result");

  // first header is always counted
  a_used_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[32:16] >= 17'(ffha_pkg::HEADER_BYTES))
    else $error("used count below header size");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n || cfg_wr_en)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled result changed");
endmodule

bind first_fit_heap_allocator_top ffha_checker u_ffha_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tuser(out_tuser), .cfg_wr_en(cfg_wr_en)
);
`default_nettype wire

[test/tb_first_fit_heap_allocator_top.sv]
// Testbench for the first-fit heap allocator: directed and random allocate/free words.
`timescale 1ns / 100ps
`default_nettype none
module tb_first_fit_heap_allocator_top;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_wr_en;
  logic [16:0] cfg_wr_data;

  first_fit_heap_allocator_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] offset;
    logic [16:0] used;
  } alloc_result_t;

  // heap shadow, indexed by header byte offset
  int unsigned   arena_len;
  int unsigned   used_total;
  int unsigned   blk_len[ffha_pkg::ARENA_MAX];
  bit            blk_used[ffha_pkg::ARENA_MAX];
  bit            blk_start[ffha_pkg::ARENA_MAX];
  alloc_result_t pending_q[$];
  int unsigned   live_q[$];
  int            errors;
  int            idle_cycles;
  bit            hold_off;
  bit            done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // rebuild the arena as one free block
  task automatic heap_init(input int unsigned bytes);
    if (bytes > ffha_pkg::ARENA_MAX) bytes = ffha_pkg::ARENA_MAX;
    if (bytes < ffha_pkg::ARENA_MIN) bytes = ffha_pkg::ARENA_MIN;
    arena_len = bytes;
    for (int i = 0; i < ffha_pkg::ARENA_MAX; i++) begin
      blk_used[i] = 1'b0;
      blk_start[i] = 1'b0;
    end
    blk_start[0] = 1'b1;
    blk_len[0] = bytes - ffha_pkg::HEADER_BYTES;
    used_total = ffha_pkg::HEADER_BYTES;
  endtask

  task automatic heap_merge();
    int unsigned pos;
    int unsigned nx;
    pos = 0;
    while (pos < arena_len) begin
      nx = pos + ffha_pkg::HEADER_BYTES + blk_len[pos];
      if (!blk_used[pos] && nx < arena_len && !blk_used[nx]) begin
        blk_len[pos] += ffha_pkg::HEADER_BYTES + blk_len[nx];
        blk_start[nx] = 1'b0;
      end else begin
        pos = nx;
      end
    end
  endtask

  // predict one word's result and update the shadow
  task automatic heap_apply(input logic cmd, input logic [16:0] req, input logic [15:0] addr,
                            output alloc_result_t res);
    int unsigned want;
    int unsigned pos;
    int unsigned nb;
    res.status = ffha_pkg::ST_ALLOC_FAIL;
    res.offset = '0;
    if (cmd == ffha_pkg::CMD_ALLOC) begin
      if (req != 0) begin
        want = (int'(req) + 3) & ~3;
        pos = 0;
        while (pos < arena_len) begin
          if (!blk_used[pos] && blk_len[pos] >= want) begin
            if (blk_len[pos] >= want + ffha_pkg::HEADER_BYTES + ffha_pkg::SPLIT_SLACK) begin
              nb = pos + ffha_pkg::HEADER_BYTES + want;
              blk_start[nb] = 1'b1;
              blk_used[nb] = 1'b0;
              blk_len[nb] = blk_len[pos] - want - ffha_pkg::HEADER_BYTES;
              blk_len[pos] = want;
            end
            blk_used[pos] = 1'b1;
            used_total += ffha_pkg::HEADER_BYTES + blk_len[pos];
            res.status = ffha_pkg::ST_ALLOC_OK;
            res.offset = 16'(pos + ffha_pkg::HEADER_BYTES);
            live_q.push_back(pos + ffha_pkg::HEADER_BYTES);
            break;
          end
          pos = pos + ffha_pkg::HEADER_BYTES + blk_len[pos];
        end
      end
    end else begin
      res.status = ffha_pkg::ST_FREE_BAD;
      if (addr >= ffha_pkg::HEADER_BYTES) begin
        pos = addr - ffha_pkg::HEADER_BYTES;
        if (pos < arena_len && blk_start[pos] && blk_used[pos]) begin
          used_total -= ffha_pkg::HEADER_BYTES + blk_len[pos];
          blk_used[pos] = 1'b0;
          heap_merge();
          res.status = ffha_pkg::ST_FREED;
          foreach (live_q[i]) if (live_q[i] == addr) begin
            live_q.delete(i);
            break;
          end
        end
      end
    end
    res.used = 17'(used_total);
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // drop valid before any pause in sending
  task automatic release_input();
    in_tvalid <= 1'b0;
  endtask

  // send one word after a random gap; valid stays up until the next call or a pause
  task automatic send_word(input logic cmd, input logic [16:0] req, input logic [15:0] addr);
    alloc_result_t res;
    int gap;
    gap = $urandom_range(0, 13);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {7'd0, addr, req};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    heap_apply(cmd, req, addr, res);
    pending_q.push_back(res);
  endtask

  task automatic drain();
    release_input();
    while (pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // register write while idle; clearing pass follows
  task automatic set_arena(input logic [16:0] bytes);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= bytes;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    heap_init(bytes);
    live_q.delete();
  endtask

  task automatic free_random_live();
    int k;
    k = $urandom_range(0, live_q.size() - 1);
    send_word(ffha_pkg::CMD_FREE, 17'($urandom), 16'(live_q[k]));
  endtask

  // extremes, bad frees, split and no-split, merge
  task automatic test_directed();
    set_arena(17'd64);
    send_word(ffha_pkg::CMD_ALLOC, 17'd0, 16'hFFFF);
    send_word(ffha_pkg::CMD_ALLOC, 17'd1, 16'd0);
    send_word(ffha_pkg::CMD_ALLOC, 17'd24, 16'd0);
    send_word(ffha_pkg::CMD_ALLOC, 17'd4, 16'd0);
    send_word(ffha_pkg::CMD_FREE, 17'h1FFFF, 16'd0);
    send_word(ffha_pkg::CMD_FREE, 17'd0, 16'd11);
    send_word(ffha_pkg::CMD_FREE, 17'd0, 16'd13);
    send_word(ffha_pkg::CMD_FREE, 17'd0, 16'hFFFF);
    send_word(ffha_pkg::CMD_FREE, 17'd0, 16'd12);
    send_word(ffha_pkg::CMD_FREE, 17'd0, 16'd12);
    send_word(ffha_pkg::CMD_ALLOC, 17'd52, 16'd0);
    send_word(ffha_pkg::CMD_FREE, 17'd0, 16'd12);
    set_arena(17'h1FFFF);
    send_word(ffha_pkg::CMD_ALLOC, 17'h1FFFF, 16'd0);
    send_word(ffha_pkg::CMD_ALLOC, 17'd65524, 16'd0);
    send_word(ffha_pkg::CMD_FREE, 17'd0, 16'd12);
    send_word(ffha_pkg::CMD_ALLOC, 17'd100, 16'd0);
    send_word(ffha_pkg::CMD_ALLOC, 17'd200, 16'd0);
    send_word(ffha_pkg::CMD_ALLOC, 17'd300, 16'd0);
    send_word(ffha_pkg::CMD_FREE, 17'd0, 16'd124);
    send_word(ffha_pkg::CMD_FREE, 17'd0, 16'd12);
    send_word(ffha_pkg::CMD_FREE, 17'd0, 16'd336);
    send_word(ffha_pkg::CMD_FREE, 17'd0, 16'd65535);
    set_arena(17'd10);
  endtask

  // mostly valid alloc/free traffic with small sizes
  task automatic test_random(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) send_word(ffha_pkg::CMD_ALLOC, 17'($urandom_range(1, 160)), 16'($urandom));
      else if (r < 85 && live_q.size() != 0) free_random_live();
      else if (r < 92) send_word(ffha_pkg::CMD_FREE, 17'($urandom), 16'($urandom));
      else send_word(ffha_pkg::CMD_ALLOC, 17'($urandom), 16'($urandom));
    end
  endtask

  // receiver stalls long while sender keeps offering
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        for (int i = 0; i < 8; i++)
          send_word(ffha_pkg::CMD_ALLOC, 17'($urandom_range(1, 40)), 16'd0);
        release_input();
      end
    join
  endtask

  // result checker and ready randomizer
  initial begin
    int gap;
    alloc_result_t exp_res;
    out_tready <= 1'b0;
    gap = 0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        if (pending_q.size() == 0) begin
          report_mismatch("unexpected word", 0, 0);
        end else begin
          exp_res = pending_q.pop_front();
          if (out_tuser !== exp_res.status)
            report_mismatch("status", out_tuser, exp_res.status);
          if (out_tdata[15:0] !== exp_res.offset)
            report_mismatch("payload_offset", out_tdata[15:0], exp_res.offset);
          if (out_tdata[32:16] !== exp_res.used)
            report_mismatch("used_bytes", out_tdata[32:16], exp_res.used);
        end
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      end
      if (hold_off) begin
        out_tready <= 1'b0;
      end else if (gap > 0) begin
        gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog on accepted words
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || done) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= 60000) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    errors = 0;
    hold_off = 1'b0;
    done = 1'b0;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= '0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    heap_init(65536);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(250);
    test_backpressure();
    set_arena(17'd3000);
    test_random(150);
    set_arena(17'd65536);
    test_random(130);
    drain();
    done = 1'b1;
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
